// ----- hw/rtl/dnm_pkg.sv -----
// Shared types, constants and command/status structs of the descriptor matcher.
package dnm_pkg;

  localparam int MAX_REFS = 256;
  localparam int DESC_LEN = 8;
  localparam int FRAC_BITS = 4;

  localparam int ELEM_W  = 13;
  localparam int COORD_W = 11;
  localparam int DIST_W  = 16;
  localparam int NUM_W   = 16;
  localparam int IDX_W   = $clog2(MAX_REFS);
  localparam int CNT_W   = $clog2(MAX_REFS + 1);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [DESC_LEN-1:0] desc_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ELEM_W-1:0] absdiff_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  // One stored table entry besides its descriptor.
  typedef struct packed {
    logic   ok;
    coord_t x;
    coord_t y;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_entry;
    logic clear_table;
    logic start_query;
    logic issue_read;
    logic emit;
  } dnm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic pipe_empty;
    logic found;
    logic out_free;
  } dnm_stat_t;

endpackage

// ----- hw/rtl/dnm_if.sv -----
// Valid/ready channel interfaces for input items and match results.
interface dnm_in_if;
  import dnm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic signed [ELEM_W-1:0] desc_0;
  logic signed [ELEM_W-1:0] desc_1;
  logic signed [ELEM_W-1:0] desc_2;
  logic signed [ELEM_W-1:0] desc_3;
  logic signed [ELEM_W-1:0] desc_4;
  logic signed [ELEM_W-1:0] desc_5;
  logic signed [ELEM_W-1:0] desc_6;
  logic signed [ELEM_W-1:0] desc_7;
  logic                  has_descriptor;
  logic [COORD_W-1:0]    point_x;
  logic [COORD_W-1:0]    point_y;

  modport source (
    output valid, kind, desc_0, desc_1, desc_2, desc_3, desc_4, desc_5, desc_6, desc_7,
    output has_descriptor, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, kind, desc_0, desc_1, desc_2, desc_3, desc_4, desc_5, desc_6, desc_7,
    input  has_descriptor, point_x, point_y,
    output ready
  );
endinterface

interface dnm_out_if;
  import dnm_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] query_x;
  logic [COORD_W-1:0] query_y;
  logic [COORD_W-1:0] match_x;
  logic [COORD_W-1:0] match_y;
  logic [IDX_W-1:0]   match_index;
  logic [DIST_W-1:0]  match_distance;
  logic [NUM_W-1:0]   match_number;

  modport source (
    output valid, query_x, query_y, match_x, match_y, match_index, match_distance,
    output match_number,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, match_x, match_y, match_index, match_distance,
    input  match_number,
    output ready
  );
endinterface

// ----- hw/rtl/dnm_ctrl.sv -----
// Controller state machine: accepts items and sequences the table scan.
module dnm_ctrl
  import dnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [1:0] in_kind,
  input  logic      in_has,
  output logic      in_ready,
  input  dnm_stat_t stat,
  output dnm_cmd_t  cmd
);

  state_t state, state_next;
  logic   take;

  assign take = in_valid && (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take && in_kind == KIND_QUERY && in_has && !stat.count_zero) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.pipe_empty) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.found || stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (take) begin
          case (in_kind)
            KIND_LOAD:  cmd.load_entry  = 1'b1;
            KIND_CLEAR: cmd.clear_table = 1'b1;
            KIND_QUERY: cmd.start_query = in_has;
            default:    cmd = '0;
          endcase
        end
      end
      S_SCAN:  cmd.issue_read = 1'b1;
      S_DRAIN: cmd = '0;
      S_EMIT:  cmd.emit = stat.found && stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/dnm_datapath.sv -----
// Datapath: reference table memory, L1 distance pipeline, best tracker and result register.
module dnm_datapath
  import dnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  desc_t     desc,
  input  logic      has_descriptor,
  input  coord_t    point_x,
  input  coord_t    point_y,
  input  dnm_cmd_t  cmd,
  output dnm_stat_t stat,
  dnm_out_if.source res
);

  // Table storage, contents undefined until loaded.
  desc_t  desc_mem [MAX_REFS];
  entry_t ent_mem  [MAX_REFS];

  logic [CNT_W-1:0] ref_count;
  logic [NUM_W-1:0] match_num;
  logic [CNT_W-1:0] scan_addr;
  logic             table_full;

  // Query under search.
  desc_t  q_desc;
  coord_t q_x;
  coord_t q_y;

  // Pipeline: read, absolute differences, sum.
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  desc_t            rd_desc;
  entry_t           rd_ent;
  logic             s2_valid;
  logic [IDX_W-1:0] s2_idx;
  entry_t           s2_ent;
  absdiff_t         s2_abs [DESC_LEN];
  absdiff_t         abs_next [DESC_LEN];
  logic             s3_valid;
  logic [IDX_W-1:0] s3_idx;
  entry_t           s3_ent;
  dist_t            s3_dist;
  dist_t            s3_dist_next;

  // Best entry so far.
  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  dist_t            best_dist;
  coord_t           best_x;
  coord_t           best_y;
  logic             better;

  // Result register.
  logic             out_valid;

  assign table_full = (ref_count == CNT_W'(MAX_REFS));

  // Entry count and match counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
      match_num <= '0;
    end else if (cmd.clear_table) begin
      ref_count <= '0;
      match_num <= '0;
    end else begin
      if (cmd.load_entry && !table_full) begin
        ref_count <= ref_count + 1'b1;
      end
      if (cmd.emit) begin
        match_num <= match_num + 1'b1;
      end
    end
  end

  // Table write on load, registered read during the scan.
  always_ff @(posedge clk) begin
    if (cmd.load_entry && !table_full) begin
      desc_mem[ref_count[IDX_W-1:0]] <= desc;
      ent_mem[ref_count[IDX_W-1:0]]  <= '{ok: has_descriptor, x: point_x, y: point_y};
    end
    if (cmd.issue_read) begin
      rd_desc <= desc_mem[scan_addr[IDX_W-1:0]];
      rd_ent  <= ent_mem[scan_addr[IDX_W-1:0]];
    end
  end

  // Query capture and scan address.
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      q_desc    <= desc;
      q_x       <= point_x;
      q_y       <= point_y;
      scan_addr <= '0;
    end else if (cmd.issue_read) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  // Absolute difference per lane.
  always_comb begin
    logic signed [ELEM_W:0] diff;
    for (int k = 0; k < DESC_LEN; k++) begin
      diff = {q_desc[k][ELEM_W-1], q_desc[k]} - {rd_desc[k][ELEM_W-1], rd_desc[k]};
      abs_next[k] = diff[ELEM_W] ? ELEM_W'(-diff) : diff[ELEM_W-1:0];
    end
  end

  // Lane sum.
  always_comb begin
    s3_dist_next = '0;
    for (int k = 0; k < DESC_LEN; k++) begin
      s3_dist_next = s3_dist_next + DIST_W'(s2_abs[k]);
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue_read;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    s1_idx  <= scan_addr[IDX_W-1:0];
    s2_idx  <= s1_idx;
    s2_ent  <= rd_ent;
    s2_abs  <= abs_next;
    s3_idx  <= s2_idx;
    s3_ent  <= s2_ent;
    s3_dist <= s3_dist_next;
  end

  // Strict less-than keeps the lowest index among equal distances.
  assign better = s3_valid && s3_ent.ok && (!best_found || s3_dist < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (cmd.start_query) begin
      best_found <= 1'b0;
    end else if (better) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_idx  <= s3_idx;
      best_dist <= s3_dist;
      best_x    <= s3_ent.x;
      best_y    <= s3_ent.y;
    end
  end

  // Result register; loads when the receiver has taken the previous transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.query_x        <= q_x;
      res.query_y        <= q_y;
      res.match_x        <= best_x;
      res.match_y        <= best_y;
      res.match_index    <= best_idx;
      res.match_distance <= best_dist;
      res.match_number   <= match_num;
    end
  end

  assign res.valid = out_valid;

  // Status to the controller.
  assign stat.count_zero = (ref_count == '0);
  assign stat.scan_last  = (scan_addr == ref_count - 1'b1);
  assign stat.pipe_empty = !s1_valid && !s2_valid && !s3_valid;
  assign stat.found      = best_found;
  assign stat.out_free   = !out_valid || res.ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ref_count <= CNT_W'(MAX_REFS))
    else $error("reference count above table size");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || res.ready))
    else $error("result register overwritten before transfer");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |-> (scan_addr < ref_count))
    else $error("scan read beyond stored entries");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_entry && table_full) |=> table_full)
    else $error("load into full table changed the count");
`endif

endmodule

// ----- hw/rtl/descriptor_nearest_match_l1.sv -----
// Top level of the brute-force L1 nearest-neighbor descriptor matcher.
//
// Input channel "items" carries load, query and clear items; output channel
// "results" carries one result per query that finds a valid stored entry.
// A load writes the descriptor, point and valid mark into the next free
// table slot; loads past 256 entries are dropped. A clear empties the
// table and restarts match numbering.
// A query scans the stored entries through one memory read port, one entry
// with all eight lanes per cycle, followed by a three-stage distance
// pipeline: once the pipeline has drained, the result is written to the
// output register, and only then is the next item taken. A query without
// a descriptor, or against an empty table, gives no result; a query with
// no valid entry stored gives no result either.
// The result sits in an output register, so new items are taken while it
// waits; a stalled receiver only holds the block once the next query result
// is ready to be written. Synchronous reset empties the table, zeroes the
// match counter and drops any pending result.
module descriptor_nearest_match_l1
  import dnm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  dnm_in_if.sink     items,
  dnm_out_if.source  results
);

  dnm_cmd_t  cmd;
  dnm_stat_t stat;
  desc_t     desc;

  assign desc[0] = items.desc_0;
  assign desc[1] = items.desc_1;
  assign desc[2] = items.desc_2;
  assign desc[3] = items.desc_3;
  assign desc[4] = items.desc_4;
  assign desc[5] = items.desc_5;
  assign desc[6] = items.desc_6;
  assign desc[7] = items.desc_7;

  dnm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_kind  (items.kind),
    .in_has   (items.has_descriptor),
    .in_ready (items.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dnm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .desc           (desc),
    .has_descriptor (items.has_descriptor),
    .point_x        (items.point_x),
    .point_y        (items.point_y),
    .cmd            (cmd),
    .stat           (stat),
    .res            (results)
  );

endmodule
